// File: rtl/rlpm_pkg.sv
package rlpm_pkg;

	// channel plan
	localparam int CHANNEL_COUNT = 13;
	localparam int CHAN_W        = 4;
	localparam int GW_W          = 48;
	localparam int TIME_W        = 32;
	localparam int FAIL_W        = 8;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 32;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_DWELL_TIME   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HB_INTERVAL  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINK_TIMEOUT = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FAIL_LIMIT   = 2'd3;

	// configuration reset values
	localparam logic [TIME_W-1:0] DWELL_TIME_RST   = 32'd100;
	localparam logic [TIME_W-1:0] HB_INTERVAL_RST  = 32'd1000;
	localparam logic [TIME_W-1:0] LINK_TIMEOUT_RST = 32'd5000;
	localparam logic [FAIL_W-1:0] FAIL_LIMIT_RST   = 8'd5;

	// event codes
	typedef enum logic [2:0] {
		REQ_RESTART   = 3'd0,
		REQ_HOP_TICK  = 3'd1,
		REQ_BEACON    = 3'd2,
		REQ_HB_SENT   = 3'd3,
		REQ_ACTIVITY  = 3'd4,
		REQ_SEND_FAIL = 3'd5,
		REQ_SEND_OK   = 3'd6,
		REQ_TIMEOUT   = 3'd7
	} req_t;

	typedef struct packed {
		req_t              req_type;
		logic [TIME_W-1:0] now_time;
		logic [7:0]        beacon_channel;
		logic [GW_W-1:0]   beacon_gateway;
	} event_word_t;

	typedef struct packed {
		logic              took_effect;
		logic [CHAN_W-1:0] channel_now;
		logic              paired_now;
		logic              heartbeat_due;
		logic [GW_W-1:0]   gateway_address;
	} status_word_t;

	typedef struct packed {
		logic [TIME_W-1:0] dwell_time;
		logic [TIME_W-1:0] heartbeat_interval;
		logic [TIME_W-1:0] link_timeout;
		logic [FAIL_W-1:0] failure_limit;
	} cfg_t;

endpackage

// File: rtl/rlpm_core.sv
module rlpm_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  rlpm_pkg::event_word_t  word,
	input  rlpm_pkg::cfg_t         cfg,
	output rlpm_pkg::status_word_t result
);

	// link state
	logic                                paired_q;
	logic [rlpm_pkg::CHAN_W-1:0]         channel_q;
	logic [rlpm_pkg::TIME_W-1:0]         last_hop_q;
	logic [rlpm_pkg::TIME_W-1:0]         last_hb_q;
	logic [rlpm_pkg::TIME_W-1:0]         last_act_q;
	logic [rlpm_pkg::FAIL_W-1:0]         fail_cnt_q;
	logic [rlpm_pkg::GW_W-1:0]           gateway_q;

	logic                                paired_d;
	logic [rlpm_pkg::CHAN_W-1:0]         channel_d;
	logic [rlpm_pkg::TIME_W-1:0]         last_hop_d;
	logic [rlpm_pkg::TIME_W-1:0]         last_hb_d;
	logic [rlpm_pkg::TIME_W-1:0]         last_act_d;
	logic [rlpm_pkg::FAIL_W-1:0]         fail_cnt_d;
	logic [rlpm_pkg::GW_W-1:0]           gateway_d;
	logic                                effect;

	logic [rlpm_pkg::TIME_W-1:0]         since_hop;
	logic [rlpm_pkg::TIME_W-1:0]         since_act;
	logic [rlpm_pkg::TIME_W-1:0]         since_hb;
	logic                                beacon_ok;
	logic [rlpm_pkg::FAIL_W-1:0]         fail_inc;
	logic [rlpm_pkg::CHAN_W-1:0]         channel_next;

	// elapsed times, modulo 2^32
	assign since_hop = word.now_time - last_hop_q;
	assign since_act = word.now_time - last_act_q;
	assign since_hb  = word.now_time - last_hb_d;

	assign beacon_ok = (word.beacon_channel != 8'd0)
		&& (word.beacon_channel <= 8'(rlpm_pkg::CHANNEL_COUNT));
	assign fail_inc  = (fail_cnt_q == '1) ? fail_cnt_q : fail_cnt_q + 1'b1;
	assign channel_next = (channel_q >= rlpm_pkg::CHAN_W'(rlpm_pkg::CHANNEL_COUNT))
		? rlpm_pkg::CHAN_W'(1) : channel_q + 1'b1;

	// next state for one event
	always_comb begin
		paired_d   = paired_q;
		channel_d  = channel_q;
		last_hop_d = last_hop_q;
		last_hb_d  = last_hb_q;
		last_act_d = last_act_q;
		fail_cnt_d = fail_cnt_q;
		gateway_d  = gateway_q;
		effect     = 1'b0;
		case (word.req_type)
			rlpm_pkg::REQ_RESTART: begin
				paired_d   = 1'b0;
				channel_d  = rlpm_pkg::CHAN_W'(1);
				last_hop_d = word.now_time;
				last_hb_d  = '0;
				last_act_d = word.now_time;
				fail_cnt_d = '0;
				gateway_d  = '0;
			end
			rlpm_pkg::REQ_HOP_TICK: begin
				if (!paired_q && since_hop >= cfg.dwell_time) begin
					last_hop_d = word.now_time;
					channel_d  = channel_next;
					effect     = 1'b1;
				end
			end
			rlpm_pkg::REQ_BEACON: begin
				if (beacon_ok) begin
					channel_d  = word.beacon_channel[rlpm_pkg::CHAN_W-1:0];
					gateway_d  = word.beacon_gateway;
					if (!paired_q) begin
						paired_d  = 1'b1;
						last_hb_d = word.now_time;
					end
					last_act_d = word.now_time;
					fail_cnt_d = '0;
					effect     = 1'b1;
				end
			end
			rlpm_pkg::REQ_HB_SENT: begin
				last_hb_d = word.now_time;
			end
			rlpm_pkg::REQ_ACTIVITY: begin
				last_act_d = word.now_time;
				fail_cnt_d = '0;
			end
			rlpm_pkg::REQ_SEND_FAIL: begin
				fail_cnt_d = fail_inc;
				// too many failures: back to scanning from last activity
				if (fail_inc >= cfg.failure_limit) begin
					paired_d   = 1'b0;
					fail_cnt_d = '0;
					last_hop_d = last_act_q;
					gateway_d  = '0;
				end
			end
			rlpm_pkg::REQ_SEND_OK: begin
				fail_cnt_d = '0;
			end
			rlpm_pkg::REQ_TIMEOUT: begin
				if (paired_q && since_act >= cfg.link_timeout) begin
					paired_d   = 1'b0;
					fail_cnt_d = '0;
					last_hop_d = word.now_time;
					gateway_d  = '0;
					effect     = 1'b1;
				end
			end
			default: begin
				effect = 1'b0;
			end
		endcase
	end

	// result from the state after the event
	always_comb begin
		result.took_effect     = effect;
		result.channel_now     = channel_d;
		result.paired_now      = paired_d;
		result.heartbeat_due   = paired_d && (since_hb >= cfg.heartbeat_interval);
		result.gateway_address = gateway_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paired_q   <= 1'b0;
			channel_q  <= rlpm_pkg::CHAN_W'(1);
			last_hop_q <= '0;
			last_hb_q  <= '0;
			last_act_q <= '0;
			fail_cnt_q <= '0;
			gateway_q  <= '0;
		end else if (fire) begin
			paired_q   <= paired_d;
			channel_q  <= channel_d;
			last_hop_q <= last_hop_d;
			last_hb_q  <= last_hb_d;
			last_act_q <= last_act_d;
			fail_cnt_q <= fail_cnt_d;
			gateway_q  <= gateway_d;
		end
	end

endmodule

// File: rtl/radio_link_pairing_manager_top.sv
// path: an accepted word passes the input register, then the status register
// throughput: one event word per cycle unless status_stall holds the output, set by the
// single input register and the status register around the state update logic
// reset: arst_n clears both valid flags, puts the link in scanning on channel 1 with
// all times, failure count and gateway at zero, and loads the default configuration
module radio_link_pairing_manager_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  event_valid,
	output logic                                  event_stall,
	input  rlpm_pkg::event_word_t                 event_word,
	output logic                                  status_valid,
	input  logic                                  status_stall,
	output rlpm_pkg::status_word_t                status_word,
	input  logic                                  cfg_we,
	input  logic [rlpm_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [rlpm_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic                   valid_s1;
	rlpm_pkg::event_word_t  word_s1;
	logic                   status_valid_q;
	rlpm_pkg::status_word_t status_word_q;
	rlpm_pkg::status_word_t result;
	rlpm_pkg::cfg_t         cfg_q;
	logic                   advance;
	logic                   load_s1;

	// the input stage moves on when the status register is free or being taken
	assign advance     = !status_valid_q || !status_stall;
	// the input register takes a word when it is empty or its word moves on
	assign load_s1     = advance || !valid_s1;
	assign event_stall = !load_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dwell_time         <= rlpm_pkg::DWELL_TIME_RST;
			cfg_q.heartbeat_interval <= rlpm_pkg::HB_INTERVAL_RST;
			cfg_q.link_timeout       <= rlpm_pkg::LINK_TIMEOUT_RST;
			cfg_q.failure_limit      <= rlpm_pkg::FAIL_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rlpm_pkg::CFG_DWELL_TIME:   cfg_q.dwell_time         <= cfg_data;
				rlpm_pkg::CFG_HB_INTERVAL:  cfg_q.heartbeat_interval <= cfg_data;
				rlpm_pkg::CFG_LINK_TIMEOUT: cfg_q.link_timeout       <= cfg_data;
				rlpm_pkg::CFG_FAIL_LIMIT: begin
					cfg_q.failure_limit <= cfg_data[rlpm_pkg::FAIL_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= event_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && event_valid) begin
			word_s1 <= event_word;
		end
	end

	// state update and status computation
	rlpm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (valid_s1 && advance),
		.word   (word_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// status register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_valid_q <= 1'b0;
		end else if (advance) begin
			status_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status_word_q <= result;
		end
	end

	assign status_valid = status_valid_q;
	assign status_word  = status_word_q;

	// checks
	property p_stall_needs_word;
		@(posedge clk) disable iff (!arst_n)
		event_stall |-> (valid_s1 && status_valid_q && status_stall);
	endproperty
	a_stall_needs_word: assert property (p_stall_needs_word)
		else $error("input stalled without a pending word");

	property p_scan_no_gateway;
		@(posedge clk) disable iff (!arst_n)
		(status_valid && !status_word.paired_now) |-> (status_word.gateway_address == '0);
	endproperty
	a_scan_no_gateway: assert property (p_scan_no_gateway)
		else $error("gateway reported while scanning");

	property p_channel_range;
		@(posedge clk) disable iff (!arst_n)
		status_valid |-> (status_word.channel_now != '0
			&& status_word.channel_now <= rlpm_pkg::CHAN_W'(rlpm_pkg::CHANNEL_COUNT));
	endproperty
	a_channel_range: assert property (p_channel_range)
		else $error("channel out of range");

	property p_hb_only_paired;
		@(posedge clk) disable iff (!arst_n)
		(status_valid && status_word.heartbeat_due) |-> status_word.paired_now;
	endproperty
	a_hb_only_paired: assert property (p_hb_only_paired)
		else $error("heartbeat due while scanning");

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int CLK_PERIOD     = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT   = 10;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             event_valid;
	logic                             event_stall;
	rlpm_pkg::event_word_t            event_word;
	logic                             status_valid;
	logic                             status_stall;
	rlpm_pkg::status_word_t           status_word;
	logic                             cfg_we;
	logic [rlpm_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [rlpm_pkg::CFG_DATA_W-1:0]  cfg_data;

	radio_link_pairing_manager_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.event_word   (event_word),
		.status_valid (status_valid),
		.status_stall (status_stall),
		.status_word  (status_word),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// predicted link state and settings, starting from reset values
	logic                        lk_paired   = 1'b0;
	logic [rlpm_pkg::CHAN_W-1:0] lk_channel  = rlpm_pkg::CHAN_W'(1);
	logic [rlpm_pkg::TIME_W-1:0] lk_hop_time = '0;
	logic [rlpm_pkg::TIME_W-1:0] lk_hb_time  = '0;
	logic [rlpm_pkg::TIME_W-1:0] lk_act_time = '0;
	logic [rlpm_pkg::FAIL_W-1:0] lk_fails    = '0;
	logic [rlpm_pkg::GW_W-1:0]   lk_gateway  = '0;
	rlpm_pkg::cfg_t              link_cfg    = '{rlpm_pkg::DWELL_TIME_RST,
		rlpm_pkg::HB_INTERVAL_RST, rlpm_pkg::LINK_TIMEOUT_RST, rlpm_pkg::FAIL_LIMIT_RST};

	rlpm_pkg::status_word_t      pending_status[$];
	int                          status_errors = 0;
	int                          events_sent   = 0;
	int                          words_checked = 0;
	int                          setups_done   = 0;
	int                          burst_left    = 0;
	int                          idle_cycles   = 0;
	logic [rlpm_pkg::TIME_W-1:0] sim_ms        = '0;

	stall_mode_t       stall_mode   = STALL_NONE;
	int                stall_span   = 0;
	int                stall_period = 2;
	int                stall_phase  = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// time since a stamp, modulo 2^32
	function automatic logic [rlpm_pkg::TIME_W-1:0] elapsed(
		input logic [rlpm_pkg::TIME_W-1:0] now_ms,
		input logic [rlpm_pkg::TIME_W-1:0] since);
		return now_ms - since;
	endfunction

	// back to scanning, channel kept
	function automatic void drop_link(input logic [rlpm_pkg::TIME_W-1:0] hop_ms);
		lk_paired   = 1'b0;
		lk_fails    = '0;
		lk_hop_time = hop_ms;
		lk_gateway  = '0;
	endfunction

	// apply one event to the predicted state and return the status it should give
	function automatic rlpm_pkg::status_word_t advance_link(input rlpm_pkg::event_word_t ev);
		rlpm_pkg::status_word_t      st;
		logic                        took;
		logic [rlpm_pkg::TIME_W-1:0] now_ms;
		took   = 1'b0;
		now_ms = ev.now_time;
		case (ev.req_type)
			rlpm_pkg::REQ_RESTART: begin
				lk_paired   = 1'b0;
				lk_channel  = rlpm_pkg::CHAN_W'(1);
				lk_hop_time = now_ms;
				lk_hb_time  = '0;
				lk_act_time = now_ms;
				lk_fails    = '0;
				lk_gateway  = '0;
			end
			rlpm_pkg::REQ_HOP_TICK: begin
				if (!lk_paired && elapsed(now_ms, lk_hop_time) >= link_cfg.dwell_time) begin
					lk_hop_time = now_ms;
					lk_channel  = (lk_channel >= rlpm_pkg::CHAN_W'(rlpm_pkg::CHANNEL_COUNT))
						? rlpm_pkg::CHAN_W'(1) : lk_channel + rlpm_pkg::CHAN_W'(1);
					took = 1'b1;
				end
			end
			rlpm_pkg::REQ_BEACON: begin
				if (ev.beacon_channel >= 8'd1
					&& ev.beacon_channel <= 8'(rlpm_pkg::CHANNEL_COUNT)) begin
					lk_channel = ev.beacon_channel[rlpm_pkg::CHAN_W-1:0];
					lk_gateway = ev.beacon_gateway;
					if (!lk_paired) begin
						lk_paired  = 1'b1;
						lk_hb_time = now_ms;
					end
					lk_act_time = now_ms;
					lk_fails    = '0;
					took        = 1'b1;
				end
			end
			rlpm_pkg::REQ_HB_SENT: begin
				lk_hb_time = now_ms;
			end
			rlpm_pkg::REQ_ACTIVITY: begin
				lk_act_time = now_ms;
				lk_fails    = '0;
			end
			rlpm_pkg::REQ_SEND_FAIL: begin
				if (lk_fails != '1)
					lk_fails = lk_fails + 8'd1;
				if (lk_fails >= link_cfg.failure_limit)
					drop_link(lk_act_time);
			end
			rlpm_pkg::REQ_SEND_OK: begin
				lk_fails = '0;
			end
			default: begin
				if (lk_paired && elapsed(now_ms, lk_act_time) >= link_cfg.link_timeout) begin
					drop_link(now_ms);
					took = 1'b1;
				end
			end
		endcase
		st.took_effect     = took;
		st.channel_now     = lk_channel;
		st.paired_now      = lk_paired;
		st.heartbeat_due   = lk_paired &&
			(elapsed(now_ms, lk_hb_time) >= link_cfg.heartbeat_interval);
		st.gateway_address = lk_gateway;
		return st;
	endfunction

	// random event, times often aimed at the timer boundary that the event type looks at
	function automatic rlpm_pkg::event_word_t random_event();
		rlpm_pkg::event_word_t       ev;
		int                          roll;
		logic [rlpm_pkg::TIME_W-1:0] anchor;
		logic [rlpm_pkg::TIME_W-1:0] span;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			ev.req_type = rlpm_pkg::REQ_RESTART;
		else if (roll < 23)
			ev.req_type = rlpm_pkg::REQ_HOP_TICK;
		else if (roll < 38)
			ev.req_type = rlpm_pkg::REQ_BEACON;
		else if (roll < 48)
			ev.req_type = rlpm_pkg::REQ_HB_SENT;
		else if (roll < 60)
			ev.req_type = rlpm_pkg::REQ_ACTIVITY;
		else if (roll < 76)
			ev.req_type = rlpm_pkg::REQ_SEND_FAIL;
		else if (roll < 85)
			ev.req_type = rlpm_pkg::REQ_SEND_OK;
		else
			ev.req_type = rlpm_pkg::REQ_TIMEOUT;
		case (ev.req_type)
			rlpm_pkg::REQ_HOP_TICK: begin
				anchor = lk_hop_time;
				span   = link_cfg.dwell_time;
			end
			rlpm_pkg::REQ_TIMEOUT: begin
				anchor = lk_act_time;
				span   = link_cfg.link_timeout;
			end
			default: begin
				anchor = lk_hb_time;
				span   = link_cfg.heartbeat_interval;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < 50)
			sim_ms += $urandom_range(0, 40);
		else if (roll < 80)
			sim_ms = anchor + span + rlpm_pkg::TIME_W'($urandom_range(0, 2))
				- rlpm_pkg::TIME_W'(1);
		else if (roll < 95)
			sim_ms += $urandom_range(0, 3000);
		else
			sim_ms = $urandom();
		ev.now_time       = sim_ms;
		ev.beacon_gateway = {16'($urandom()), 32'($urandom())};
		if (ev.req_type == rlpm_pkg::REQ_BEACON && $urandom_range(0, 4) != 0)
			ev.beacon_channel = 8'($urandom_range(1, rlpm_pkg::CHANNEL_COUNT));
		else
			ev.beacon_channel = 8'($urandom());
		return ev;
	endfunction

	// send one event word in bursts with random gaps, predict on acceptance
	task automatic send_event(input rlpm_pkg::event_word_t ev);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				event_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		event_word  <= ev;
		event_valid <= 1'b1;
		@(posedge clk);
		while (event_stall)
			@(posedge clk);
		pending_status.push_back(advance_link(ev));
		events_sent++;
		burst_left--;
	endtask

	task automatic send_req(input rlpm_pkg::req_t kind,
		input logic [rlpm_pkg::TIME_W-1:0] at_ms,
		input logic [7:0] chan = 8'd0, input logic [rlpm_pkg::GW_W-1:0] gw = '0);
		rlpm_pkg::event_word_t ev;
		ev.req_type       = kind;
		ev.now_time       = at_ms;
		ev.beacon_channel = chan;
		ev.beacon_gateway = gw;
		send_event(ev);
	endtask

	// stop sending and wait for every outstanding status word
	task automatic wait_for_idle();
		event_valid <= 1'b0;
		burst_left = 0;
		while (pending_status.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [rlpm_pkg::CFG_INDEX_W-1:0] idx,
		input logic [rlpm_pkg::CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// reprogram all registers while the block is idle
	task automatic program_link(input logic [rlpm_pkg::TIME_W-1:0] dwell,
		input logic [rlpm_pkg::TIME_W-1:0] hb,
		input logic [rlpm_pkg::TIME_W-1:0] timeout_ms,
		input logic [rlpm_pkg::FAIL_W-1:0] limit);
		wait_for_idle();
		write_reg(rlpm_pkg::CFG_DWELL_TIME, dwell);
		write_reg(rlpm_pkg::CFG_HB_INTERVAL, hb);
		write_reg(rlpm_pkg::CFG_LINK_TIMEOUT, timeout_ms);
		// upper bits of the failure limit write are don't-care
		write_reg(rlpm_pkg::CFG_FAIL_LIMIT, {24'($urandom()), limit});
		cfg_we <= 1'b0;
		link_cfg.dwell_time         = dwell;
		link_cfg.heartbeat_interval = hb;
		link_cfg.link_timeout       = timeout_ms;
		link_cfg.failure_limit      = limit;
		setups_done++;
	endtask

	// hand-picked events on the reset configuration
	task automatic test_directed_events();
		send_req(rlpm_pkg::REQ_HOP_TICK, 32'd50);
		send_req(rlpm_pkg::REQ_HOP_TICK, 32'd100);
		send_req(rlpm_pkg::REQ_TIMEOUT, 32'hFFFF_FFFF);
		// beacons on channels outside the plan are dropped
		send_req(rlpm_pkg::REQ_BEACON, 32'd120, 8'd0, '1);
		send_req(rlpm_pkg::REQ_BEACON, 32'd130, 8'd14, '1);
		send_req(rlpm_pkg::REQ_BEACON, 32'd140, 8'hFF, 48'hA5A5_5A5A_0F0F);
		send_req(rlpm_pkg::REQ_SEND_FAIL, 32'd150);
		send_req(rlpm_pkg::REQ_RESTART, 32'hFFFF_FF00);
		// hop across the time wrap
		send_req(rlpm_pkg::REQ_HOP_TICK, 32'h0000_0010);
		send_req(rlpm_pkg::REQ_BEACON, 32'h0000_0020, 8'(rlpm_pkg::CHANNEL_COUNT), '1);
		// paired: hop ignored, heartbeat due until sent
		send_req(rlpm_pkg::REQ_HOP_TICK, 32'h0000_1000);
		send_req(rlpm_pkg::REQ_HB_SENT, 32'h0000_1000);
		send_req(rlpm_pkg::REQ_BEACON, 32'h0000_1100, 8'd1, '0);
		send_req(rlpm_pkg::REQ_ACTIVITY, 32'h0000_1200);
		repeat (3) send_req(rlpm_pkg::REQ_SEND_FAIL, 32'h0000_1300);
		send_req(rlpm_pkg::REQ_SEND_OK, 32'h0000_1310);
		// timeout one short of and exactly at the limit
		send_req(rlpm_pkg::REQ_TIMEOUT, 32'h0000_1200 + 32'd4999);
		send_req(rlpm_pkg::REQ_TIMEOUT, 32'h0000_1200 + 32'd5000);
		send_req(rlpm_pkg::REQ_ACTIVITY, 32'h0000_2000);
		send_req(rlpm_pkg::REQ_HB_SENT, 32'h0000_2100);
		// five failures in a row drop the link, hop clock restarts at last activity
		send_req(rlpm_pkg::REQ_BEACON, 32'h0000_2400, 8'd6, 48'h0123_4567_89AB);
		repeat (5) send_req(rlpm_pkg::REQ_SEND_FAIL, 32'h0000_2500);
		send_req(rlpm_pkg::REQ_HOP_TICK, 32'h0000_2400 + 32'd100);
		sim_ms = 32'h0000_3000;
	endtask

	// failure limits of zero, one and the maximum
	task automatic test_failure_limits();
		program_link(rlpm_pkg::DWELL_TIME_RST, rlpm_pkg::HB_INTERVAL_RST,
			rlpm_pkg::LINK_TIMEOUT_RST, 8'd0);
		send_req(rlpm_pkg::REQ_BEACON, sim_ms, 8'd7, {16'($urandom()), 32'($urandom())});
		send_req(rlpm_pkg::REQ_SEND_FAIL, sim_ms + 32'd1);
		send_req(rlpm_pkg::REQ_SEND_FAIL, sim_ms + 32'd2);
		program_link(rlpm_pkg::DWELL_TIME_RST, rlpm_pkg::HB_INTERVAL_RST,
			rlpm_pkg::LINK_TIMEOUT_RST, 8'd1);
		send_req(rlpm_pkg::REQ_BEACON, sim_ms + 32'd3, 8'd3,
			{16'($urandom()), 32'($urandom())});
		send_req(rlpm_pkg::REQ_SEND_FAIL, sim_ms + 32'd4);
		program_link(rlpm_pkg::DWELL_TIME_RST, rlpm_pkg::HB_INTERVAL_RST,
			rlpm_pkg::LINK_TIMEOUT_RST, 8'hFF);
		sim_ms += 32'd10;
		send_req(rlpm_pkg::REQ_BEACON, sim_ms, 8'd11, {16'($urandom()), 32'($urandom())});
		repeat (255) begin
			sim_ms += 32'd1;
			send_req(rlpm_pkg::REQ_SEND_FAIL, sim_ms);
		end
		send_req(rlpm_pkg::REQ_HOP_TICK, sim_ms);
	endtask

	// timers and limit at zero and at all ones
	task automatic test_config_extremes();
		program_link('0, '0, '0, '0);
		repeat (80) send_event(random_event());
		program_link('1, '1, '1, '1);
		repeat (80) send_event(random_event());
	endtask

	// random traffic over default, short and arbitrary settings
	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			case (phase % 3)
				0: program_link(rlpm_pkg::DWELL_TIME_RST, rlpm_pkg::HB_INTERVAL_RST,
					rlpm_pkg::LINK_TIMEOUT_RST, rlpm_pkg::FAIL_LIMIT_RST);
				1: program_link($urandom_range(0, 50), $urandom_range(0, 200),
					$urandom_range(0, 400), 8'($urandom_range(0, 6)));
				default: program_link($urandom(), $urandom(), $urandom(),
					8'($urandom_range(0, 255)));
			endcase
			repeat (75) send_event(random_event());
		end
	endtask

	// receiver stall pattern, switching to a random mode when its span runs out
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode   = stall_mode_t'($urandom_range(0, 3));
			stall_span   = $urandom_range(16, 96);
			stall_period = $urandom_range(2, 8);
		end
		stall_span--;
		stall_phase = (stall_phase + 1) % stall_period;
		case (stall_mode)
			STALL_NONE:  status_stall <= 1'b0;
			STALL_LIGHT: status_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: status_stall <= ($urandom_range(0, 3) != 0);
			default:     status_stall <= (stall_phase < stall_period / 2);
		endcase
	end

	// compare each status word with the oldest prediction
	always @(posedge clk) begin
		rlpm_pkg::status_word_t want;
		if (arst_n && status_valid && !status_stall) begin
			words_checked++;
			if (pending_status.size() == 0) begin
				status_errors++;
				if (status_errors <= REPORT_LIMIT)
					$display("%0t: status word %h with no event pending", $time, status_word);
			end else begin
				want = pending_status.pop_front();
				if (want.took_effect !== status_word.took_effect ||
					want.channel_now !== status_word.channel_now ||
					want.paired_now !== status_word.paired_now ||
					want.heartbeat_due !== status_word.heartbeat_due ||
					want.gateway_address !== status_word.gateway_address) begin
					status_errors++;
					if (status_errors <= REPORT_LIMIT)
						$display("%0t: exp effect %b chan %0d paired %b hb %b gw %h, got %b %0d %b %b %h",
							$time, want.took_effect, want.channel_now, want.paired_now,
							want.heartbeat_due, want.gateway_address, status_word.took_effect,
							status_word.channel_now, status_word.paired_now,
							status_word.heartbeat_due, status_word.gateway_address);
				end
			end
		end
	end

	// watchdog on cycles where no word moves
	always @(posedge clk) begin
		if (!arst_n || (event_valid && !event_stall) || (status_valid && !status_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		arst_n       <= 1'b0;
		event_valid  <= 1'b0;
		event_word   <= '0;
		status_stall <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= '0;
		cfg_data     <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_events();
		test_failure_limits();
		test_config_extremes();
		test_random_traffic();

		// drain, then wait for stray words
		wait_for_idle();
		repeat (4) @(posedge clk);
		$display("%0d events sent, %0d status words checked, %0d register setups",
			events_sent, words_checked, setups_done);
		$display("covered restarts, hops with wrap, beacons, failure limits 0/1/255, timer extremes");
		if (status_errors == 0 && pending_status.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d predictions unanswered", status_errors,
				pending_status.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
